[hdl/bmpr_pkg.sv]
package bmpr_pkg;

  localparam int DIM_BITS    = 15;
  localparam int LEN_BITS    = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  // configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_ROWS_TOP_DOWN = 2'd2;
  localparam logic [1:0] CFG_NIBBLE_MODE   = 2'd3;

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_VALUE,
    PH_DX,
    PH_DY,
    PH_ABS,
    PH_DONE,
    PH_FAIL
  } phase_e;

  // escape class of a byte read as the second byte of a pair
  typedef enum logic [1:0] {
    KIND_EOL,
    KIND_EOB,
    KIND_DELTA,
    KIND_OTHER
  } kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    kind_e      kind;
  } item_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] image_width;
    logic [DIM_BITS-1:0] image_height;
    logic                rows_top_down;
    logic                nibble_mode;
  } cfg_t;

  typedef struct packed {
    logic                span_valid;
    logic [DIM_BITS-1:0] out_row;
    logic [DIM_BITS-1:0] start_column;
    logic [LEN_BITS-1:0] span_length;
    logic [7:0]          even_index;
    logic [7:0]          odd_index;
    logic                stream_done;
    logic                stream_failed;
  } result_t;

endpackage

[hdl/bmpr_fifo.sv]
module bmpr_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrBits = $clog2(bmpr_pkg::QUEUE_DEPTH);
  localparam int CntBits = $clog2(bmpr_pkg::QUEUE_DEPTH + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(bmpr_pkg::QUEUE_DEPTH - 1);
  localparam logic [CntBits-1:0] FullCnt = CntBits'(bmpr_pkg::QUEUE_DEPTH);

  logic [WIDTH-1:0]   mem_q [bmpr_pkg::QUEUE_DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntBits'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[hdl/bmpr_front.sv]
module bmpr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [7:0]      data_byte_i,
  input  logic            final_byte_i,
  output logic            full_o,
  input  logic            take_i,
  output bmpr_pkg::item_t item_o,
  output logic            item_valid_o
);

  bmpr_pkg::item_t item_in;
  logic            item_empty;

  always_comb begin
    item_in.data = data_byte_i;
    item_in.fin  = final_byte_i;
    priority case (data_byte_i)
      8'd0:    item_in.kind = bmpr_pkg::KIND_EOL;
      8'd1:    item_in.kind = bmpr_pkg::KIND_EOB;
      8'd2:    item_in.kind = bmpr_pkg::KIND_DELTA;
      default: item_in.kind = bmpr_pkg::KIND_OTHER;
    endcase
  end

  bmpr_fifo #(
    .WIDTH($bits(bmpr_pkg::item_t))
  ) u_item_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .wdata_i(item_in),
    .full_o (full_o),
    .pop_i  (take_i),
    .rdata_o(item_o),
    .empty_o(item_empty)
  );

  assign item_valid_o = !item_empty;

endmodule

[hdl/bmpr_back.sv]
module bmpr_back #(
  parameter int COORD_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bmpr_pkg::cfg_t    cfg_i,
  input  bmpr_pkg::item_t   item_i,
  input  logic              item_valid_i,
  output logic              take_o,
  input  logic              res_ready_i,
  output bmpr_pkg::result_t res_o,
  output logic              res_valid_o
);

  localparam int CB = COORD_BITS;
  localparam int DB = bmpr_pkg::DIM_BITS;

  bmpr_pkg::phase_e phase_q, phase_d;
  logic [CB-1:0]    pen_col_q, pen_col_d;
  logic [CB-1:0]    pen_row_q, pen_row_d;
  logic [7:0]       held_count_q, held_count_d;
  logic [7:0]       abs_left_q, abs_left_d;
  logic             pad_q, pad_d;
  logic [7:0]       held_dx_q, held_dx_d;

  logic          finished;
  logic [7:0]    span_n;
  logic          span_vis;
  logic [7:0]    even_idx, odd_idx;
  logic [7:0]    col_add, row_add;
  logic [CB:0]   col_sum, row_sum;
  logic [CB-1:0] col_sat, row_sat;
  logic [CB-1:0] width_ext, height_ext, room;
  logic [7:0]    span_len;
  logic [DB-1:0] dest_row;
  logic [8:0]    abs_inc;
  logic          abs_odd_bytes;

  assign finished = (phase_q == bmpr_pkg::PH_DONE) || (phase_q == bmpr_pkg::PH_FAIL);
  assign take_o   = item_valid_i && (finished || res_ready_i);

  assign width_ext  = CB'(cfg_i.image_width);
  assign height_ext = CB'(cfg_i.image_height);

  // run length handled by this byte, zero when it paints nothing
  always_comb begin
    span_n = 8'd0;
    if (phase_q == bmpr_pkg::PH_VALUE) begin
      span_n = held_count_q;
    end else if (phase_q == bmpr_pkg::PH_ABS && abs_left_q != 8'd0) begin
      span_n = (cfg_i.nibble_mode && abs_left_q >= 8'd2) ? 8'd2 : 8'd1;
    end
  end

  always_comb begin
    if (cfg_i.nibble_mode) begin
      even_idx = {4'd0, item_i.data[7:4]};
      odd_idx  = item_i.data & bmpr_pkg::NIBBLE_MASK;
    end else begin
      even_idx = item_i.data;
      odd_idx  = item_i.data;
    end
  end

  // shared saturating adders for pen column and pen row
  assign col_add = (phase_q == bmpr_pkg::PH_DY) ? held_dx_q : span_n;
  assign row_add = (phase_q == bmpr_pkg::PH_DY) ? item_i.data : 8'd1;
  assign col_sum = {1'b0, pen_col_q} + (CB+1)'(col_add);
  assign row_sum = {1'b0, pen_row_q} + (CB+1)'(row_add);
  assign col_sat = col_sum[CB] ? '1 : col_sum[CB-1:0];
  assign row_sat = row_sum[CB] ? '1 : row_sum[CB-1:0];

  // clipping
  assign span_vis = (span_n != 8'd0) && (pen_row_q < height_ext) && (pen_col_q < width_ext);
  assign room     = width_ext - pen_col_q;
  assign span_len = (CB'(span_n) < room) ? span_n : room[7:0];
  assign dest_row = cfg_i.rows_top_down ? pen_row_q[DB-1:0]
                  : cfg_i.image_height - DB'(1) - pen_row_q[DB-1:0];

  // pad byte needed when the run's byte count is odd
  assign abs_inc       = {1'b0, item_i.data} + 9'd1;
  assign abs_odd_bytes = cfg_i.nibble_mode ? abs_inc[1] : item_i.data[0];

  // next state
  always_comb begin
    phase_d      = phase_q;
    pen_col_d    = pen_col_q;
    pen_row_d    = pen_row_q;
    held_count_d = held_count_q;
    abs_left_d   = abs_left_q;
    pad_d        = pad_q;
    held_dx_d    = held_dx_q;
    if (take_o && !finished) begin
      unique case (phase_q)
        bmpr_pkg::PH_COUNT: begin
          if (item_i.fin) begin
            phase_d = bmpr_pkg::PH_DONE;
          end else begin
            held_count_d = item_i.data;
            phase_d      = bmpr_pkg::PH_VALUE;
          end
        end
        bmpr_pkg::PH_VALUE: begin
          if (held_count_q != 8'd0) begin
            pen_col_d = col_sat;
            phase_d   = bmpr_pkg::PH_COUNT;
          end else begin
            unique case (item_i.kind)
              bmpr_pkg::KIND_EOL: begin
                pen_col_d = '0;
                pen_row_d = row_sat;
                phase_d   = bmpr_pkg::PH_COUNT;
              end
              bmpr_pkg::KIND_EOB:   phase_d = bmpr_pkg::PH_DONE;
              bmpr_pkg::KIND_DELTA: phase_d = bmpr_pkg::PH_DX;
              bmpr_pkg::KIND_OTHER: begin
                abs_left_d = item_i.data;
                pad_d      = abs_odd_bytes;
                phase_d    = bmpr_pkg::PH_ABS;
              end
              default: phase_d = bmpr_pkg::PH_FAIL;
            endcase
          end
          if (item_i.fin) begin
            if (phase_d == bmpr_pkg::PH_COUNT) begin
              phase_d = bmpr_pkg::PH_DONE;
            end else if (phase_d == bmpr_pkg::PH_DX || phase_d == bmpr_pkg::PH_ABS) begin
              phase_d = bmpr_pkg::PH_FAIL;
            end
          end
        end
        bmpr_pkg::PH_DX: begin
          held_dx_d = item_i.data;
          phase_d   = item_i.fin ? bmpr_pkg::PH_FAIL : bmpr_pkg::PH_DY;
        end
        bmpr_pkg::PH_DY: begin
          pen_col_d = col_sat;
          pen_row_d = row_sat;
          phase_d   = item_i.fin ? bmpr_pkg::PH_DONE : bmpr_pkg::PH_COUNT;
        end
        bmpr_pkg::PH_ABS: begin
          if (abs_left_q != 8'd0) begin
            pen_col_d  = col_sat;
            abs_left_d = abs_left_q - span_n;
          end else begin
            pad_d = 1'b0;
          end
          if (abs_left_d == 8'd0 && !pad_d) begin
            // run finished with the pen past the last pixel ends the picture
            if (pen_row_q >= height_ext && pen_col_d >= width_ext) begin
              phase_d = bmpr_pkg::PH_DONE;
            end else begin
              phase_d = item_i.fin ? bmpr_pkg::PH_DONE : bmpr_pkg::PH_COUNT;
            end
          end else if (item_i.fin) begin
            phase_d = bmpr_pkg::PH_FAIL;
          end
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  // result
  always_comb begin
    res_valid_o         = take_o && !finished;
    res_o.span_valid    = span_vis;
    res_o.out_row       = span_vis ? dest_row : '0;
    res_o.start_column  = span_vis ? pen_col_q[DB-1:0] : '0;
    res_o.span_length   = span_vis ? span_len : '0;
    res_o.even_index    = span_vis ? even_idx : '0;
    res_o.odd_index     = span_vis ? odd_idx : '0;
    res_o.stream_done   = (phase_d == bmpr_pkg::PH_DONE);
    res_o.stream_failed = (phase_d == bmpr_pkg::PH_FAIL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= bmpr_pkg::PH_COUNT;
      pen_col_q    <= '0;
      pen_row_q    <= '0;
      held_count_q <= '0;
      abs_left_q   <= '0;
      pad_q        <= 1'b0;
      held_dx_q    <= '0;
    end else begin
      phase_q      <= phase_d;
      pen_col_q    <= pen_col_d;
      pen_row_q    <= pen_row_d;
      held_count_q <= held_count_d;
      abs_left_q   <= abs_left_d;
      pad_q        <= pad_d;
      held_dx_q    <= held_dx_d;
    end
  end

endmodule

[hdl/bmp_rle_decoder.sv]
// Each byte accepted into the byte queue is parsed from the head of that queue, and its
// result is registered into the result queue.
// Throughput: one byte per cycle, sustained while pop keeps up; a two-entry
// byte queue and a two-entry result queue separate the parser from both sides.
// Reset (rst_ni low, asynchronous): queues empty, parser waits for a count byte,
// pen at row 0 column 0, registers back to width 1, height 1, bottom-up, RLE8.
module bmp_rle_decoder #(
  parameter int COORD_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic        span_valid_o,
  output logic [14:0] out_row_o,
  output logic [14:0] start_column_o,
  output logic [7:0]  span_length_o,
  output logic [7:0]  even_index_o,
  output logic [7:0]  odd_index_o,
  output logic        stream_done_o,
  output logic        stream_failed_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [14:0] cfg_wdata_i
);

  bmpr_pkg::cfg_t    cfg_q, cfg_d;
  bmpr_pkg::item_t   item;
  logic              item_valid, item_take;
  bmpr_pkg::result_t res_in, res_out;
  logic              res_push, res_full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        bmpr_pkg::CFG_IMAGE_WIDTH:   cfg_d.image_width   = cfg_wdata_i;
        bmpr_pkg::CFG_IMAGE_HEIGHT:  cfg_d.image_height  = cfg_wdata_i;
        bmpr_pkg::CFG_ROWS_TOP_DOWN: cfg_d.rows_top_down = cfg_wdata_i[0];
        bmpr_pkg::CFG_NIBBLE_MODE:   cfg_d.nibble_mode   = cfg_wdata_i[0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width   <= 15'd1;
      cfg_q.image_height  <= 15'd1;
      cfg_q.rows_top_down <= 1'b0;
      cfg_q.nibble_mode   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bmpr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .data_byte_i (data_byte_i),
    .final_byte_i(final_byte_i),
    .full_o      (full_o),
    .take_i      (item_take),
    .item_o      (item),
    .item_valid_o(item_valid)
  );

  bmpr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (item),
    .item_valid_i(item_valid),
    .take_o      (item_take),
    .res_ready_i (!res_full),
    .res_o       (res_in),
    .res_valid_o (res_push)
  );

  bmpr_fifo #(
    .WIDTH($bits(bmpr_pkg::result_t))
  ) u_result_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .full_o (res_full),
    .pop_i  (pop_i),
    .rdata_o(res_out),
    .empty_o(empty_o)
  );

  assign span_valid_o    = res_out.span_valid;
  assign out_row_o       = res_out.out_row;
  assign start_column_o  = res_out.start_column;
  assign span_length_o   = res_out.span_length;
  assign even_index_o    = res_out.even_index;
  assign odd_index_o     = res_out.odd_index;
  assign stream_done_o   = res_out.stream_done;
  assign stream_failed_o = res_out.stream_failed;

  // a painted span always covers at least one pixel
  a_span_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && span_valid_o) |-> (span_length_o != 8'd0))
    else $error("span with zero length");

  // a stream cannot end both cleanly and with a failure
  a_end_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> !(stream_done_o && stream_failed_o))
    else $error("done and failed together");

  // the parser never pushes a result into a full result queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result queue overflow");

  // a byte leaves the byte queue only while it holds one
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take |-> item_valid)
    else $error("byte taken from empty queue");

endmodule
